>>> rtl/utf8_stream_decoder_macros.svh
// ----------------------------------------------------------------------------
// utf8_stream_decoder_macros
// Assertion macros used by the checker file of the decoder.
// ----------------------------------------------------------------------------
`ifndef UTF8_STREAM_DECODER_MACROS_SVH
`define UTF8_STREAM_DECODER_MACROS_SVH

// The antecedent implies the consequent in the same cycle.
`define UTF8D_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |-> (cons)) else $error(msg);

// The antecedent implies the consequent in the next cycle.
`define UTF8D_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/utf8d_pkg.sv
// ----------------------------------------------------------------------------
// utf8d_pkg
// Types and constants of the UTF-8 stream decoder.
// ----------------------------------------------------------------------------
package utf8d_pkg;

  localparam int unsigned CpW = 21;

  localparam logic [CpW-1:0] ReplChar   = 21'h00FFFD;
  localparam logic [CpW-1:0] MinTwo     = 21'h000080;
  localparam logic [CpW-1:0] MinThree   = 21'h000800;
  localparam logic [CpW-1:0] MinFour    = 21'h010000;
  localparam logic [CpW-1:0] SurrLow    = 21'h00D800;
  localparam logic [CpW-1:0] SurrEnd    = 21'h00E000;
  localparam logic [CpW-1:0] MaxPlusOne = 21'h110000;

  typedef struct packed {
    logic [1:0]     rem;
    logic [1:0]     len;
    logic [CpW-1:0] acc;
  } dec_state_t;

  typedef struct packed {
    logic [CpW-1:0] code_point;
    logic           replaced;
    logic           last;
  } result_t;

  localparam dec_state_t StateIdle = '{rem: 2'd0, len: 2'd0, acc: '0};

endpackage

>>> rtl/utf8d_step.sv
// ----------------------------------------------------------------------------
// utf8d_step
// Per-beat decode logic: next sequence state and the optional result.
// ----------------------------------------------------------------------------
module utf8d_step (
  input  logic [7:0]           byte_i,
  input  logic                 last_i,
  input  utf8d_pkg::dec_state_t state_i,
  output utf8d_pkg::dec_state_t state_o,
  output logic                 emit_o,
  output utf8d_pkg::result_t   result_o
);

  always_comb begin
    logic [1:0]                conts;
    logic [utf8d_pkg::CpW-1:0] bits;
    logic                      lead_ok;
    logic [utf8d_pkg::CpW-1:0] acc_n;
    logic [1:0]                rem_n;
    logic                      scalar_ok;

    conts     = 2'd0;
    bits      = '0;
    lead_ok   = 1'b0;
    acc_n     = {state_i.acc[utf8d_pkg::CpW-7:0], byte_i[5:0]};
    rem_n     = state_i.rem - 2'd1;
    scalar_ok = 1'b0;

    state_o  = state_i;
    emit_o   = 1'b0;
    result_o = '{code_point: utf8d_pkg::ReplChar, replaced: 1'b1, last: last_i};

    if (state_i.rem == 2'd0) begin
      if (!byte_i[7]) begin
        emit_o   = 1'b1;
        result_o = '{code_point: {13'd0, byte_i}, replaced: 1'b0, last: last_i};
      end else if (byte_i[7:5] == 3'b110) begin
        conts   = 2'd1;
        bits    = {16'd0, byte_i[4:0]};
        lead_ok = 1'b1;
      end else if (byte_i[7:4] == 4'b1110) begin
        conts   = 2'd2;
        bits    = {17'd0, byte_i[3:0]};
        lead_ok = 1'b1;
      end else if (byte_i[7:3] == 5'b11110) begin
        conts   = 2'd3;
        bits    = {18'd0, byte_i[2:0]};
        lead_ok = 1'b1;
      end else begin
        emit_o = 1'b1;
      end
      if (lead_ok) begin
        if (last_i) begin
          emit_o  = 1'b1;
          state_o = utf8d_pkg::StateIdle;
        end else begin
          state_o = '{rem: conts, len: conts, acc: bits};
        end
      end
    end else if (byte_i[7:6] != 2'b10) begin
      emit_o  = 1'b1;
      state_o = utf8d_pkg::StateIdle;
    end else if (rem_n == 2'd0) begin
      case (state_i.len)
        2'd1:    scalar_ok = acc_n >= utf8d_pkg::MinTwo;
        2'd2:    scalar_ok = (acc_n >= utf8d_pkg::MinThree) &&
                             ((acc_n < utf8d_pkg::SurrLow) || (acc_n >= utf8d_pkg::SurrEnd));
        default: scalar_ok = (acc_n >= utf8d_pkg::MinFour) && (acc_n < utf8d_pkg::MaxPlusOne);
      endcase
      emit_o  = 1'b1;
      state_o = utf8d_pkg::StateIdle;
      if (scalar_ok) begin
        result_o = '{code_point: acc_n, replaced: 1'b0, last: last_i};
      end
    end else if (last_i) begin
      emit_o  = 1'b1;
      state_o = utf8d_pkg::StateIdle;
    end else begin
      state_o = '{rem: rem_n, len: state_i.len, acc: acc_n};
    end
  end

endmodule

>>> rtl/utf8_stream_decoder.sv
// ----------------------------------------------------------------------------
// utf8_stream_decoder
// UTF-8 byte stream to code points, invalid input replaced by U+FFFD.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake              Payload
// in       input      in_valid_i/in_ready_o  byte_in_i, string_end_i
// out      output     out_valid_o/out_ready_i code_point_o, replaced_o,
//                                            last_of_string_o
//
// One input beat is taken per cycle while in_ready_o is high. A finished
// result is registered in the result register, or in the skid register if
// that one is held; input stalls only when both are full. The sequence state
// updates in the accepting cycle. Reset clears it and both valid flags.
// ----------------------------------------------------------------------------
module utf8_stream_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  byte_in_i,
  input  logic        string_end_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [20:0] code_point_o,
  output logic        replaced_o,
  output logic        last_of_string_o
);

  utf8d_pkg::dec_state_t state_q, state_d, step_state;
  utf8d_pkg::result_t    step_res, out_q, out_d, skid_q, skid_d;
  logic                  step_emit;
  logic                  out_v_q, out_v_d, skid_v_q, skid_v_d;
  logic                  accept, push, pop;

  utf8d_step u_step (
    .byte_i   (byte_in_i),
    .last_i   (string_end_i),
    .state_i  (state_q),
    .state_o  (step_state),
    .emit_o   (step_emit),
    .result_o (step_res)
  );

  assign in_ready_o = !skid_v_q;
  assign accept     = in_valid_i && in_ready_o;
  assign push       = accept && step_emit;
  assign pop        = out_v_q && out_ready_i;

  always_comb begin
    state_d  = accept ? step_state : state_q;
    out_d    = out_q;
    out_v_d  = out_v_q;
    skid_d   = skid_q;
    skid_v_d = skid_v_q;
    if (skid_v_q) begin
      if (pop) begin
        out_d    = skid_q;
        skid_v_d = 1'b0;
      end
    end else if (push) begin
      if (!out_v_q || pop) begin
        out_d   = step_res;
        out_v_d = 1'b1;
      end else begin
        skid_d   = step_res;
        skid_v_d = 1'b1;
      end
    end else if (pop) begin
      out_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= utf8d_pkg::StateIdle;
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      out_v_q  <= out_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o      = out_v_q;
  assign code_point_o     = out_q.code_point;
  assign replaced_o       = out_q.replaced;
  assign last_of_string_o = out_q.last;

endmodule

>>> rtl/utf8d_checker.sv
// ----------------------------------------------------------------------------
// utf8d_checker
// Port-level checks of the UTF-8 stream decoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "utf8_stream_decoder_macros.svh"

module utf8d_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic [7:0]  byte_in_i,
  input logic        string_end_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [20:0] code_point_o,
  input logic        replaced_o,
  input logic        last_of_string_o
);

  logic [22:0] out_beat;
  logic        out_stall;
  logic        out_repl;
  logic        out_good;
  logic        in_end;
  logic        cp_repl;
  logic        cp_scalar;

  assign out_beat  = {code_point_o, replaced_o, last_of_string_o};
  assign out_stall = out_valid_o && !out_ready_i;
  assign out_repl  = out_valid_o && replaced_o;
  assign out_good  = out_valid_o && !replaced_o;
  assign in_end    = in_valid_i && in_ready_o && string_end_i;
  assign cp_repl   = code_point_o == utf8d_pkg::ReplChar;
  assign cp_scalar = (code_point_o < utf8d_pkg::SurrLow) ||
                     ((code_point_o >= utf8d_pkg::SurrEnd) &&
                      (code_point_o < utf8d_pkg::MaxPlusOne));

  `UTF8D_ASSERT_NEXT(a_out_hold, out_stall, out_valid_o && $stable(out_beat), "Beat not held.")
  `UTF8D_ASSERT_SAME(a_repl_value, out_repl, cp_repl, "Replaced beat is not U+FFFD.")
  `UTF8D_ASSERT_SAME(a_scalar_range, out_good, cp_scalar, "Beat is not a Unicode scalar.")
  `UTF8D_ASSERT_NEXT(a_end_emits, in_end, out_valid_o, "String end beat gave no result.")

endmodule

bind utf8_stream_decoder utf8d_checker u_utf8d_checker (.*);

>>> sim/utf8_stream_decoder_tb.sv
// ----------------------------------------------------------------------------
// utf8_stream_decoder_tb
// Self-checking bench for the UTF-8 stream decoder. A directed list of byte
// sequences covers the lead byte classes, overlong forms, surrogates, values
// past the Unicode range, bad continuations and strings cut short. Random
// sequences, mostly well formed, follow. Both channels idle at random, and
// the result side holds off for long stretches so the input backs up. Every
// result is compared against a decoder model kept in the scoreboard.
// ----------------------------------------------------------------------------
module utf8_stream_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ClkPeriod   = 4;
  localparam int RandomBeats = 1500;
  localparam int DrainLimit  = 1000;
  localparam int DrainCycles = 8;
  localparam int LongHoldOff = 60;
  localparam int MaxReported = 10;

  class decode_scoreboard;
    utf8d_pkg::result_t        expected_chars[$];
    logic [1:0]                conts_due;
    logic [1:0]                conts_total;
    logic [utf8d_pkg::CpW-1:0] payload;
    int                        errors;

    function new();
      conts_due   = '0;
      conts_total = '0;
      payload     = '0;
      errors      = 0;
    endfunction

    function void go_idle();
      conts_due   = '0;
      conts_total = '0;
      payload     = '0;
    endfunction

    function void push_char(logic [utf8d_pkg::CpW-1:0] cp, logic bad, logic last);
      utf8d_pkg::result_t r;
      r.code_point = cp;
      r.replaced   = bad;
      r.last       = last;
      expected_chars.push_back(r);
    endfunction

    function bit scalar_ok(logic [1:0] n, logic [utf8d_pkg::CpW-1:0] v);
      case (n)
        2'd1: return v >= utf8d_pkg::MinTwo;
        2'd2: return v >= utf8d_pkg::MinThree &&
                     (v < utf8d_pkg::SurrLow || v >= utf8d_pkg::SurrEnd);
        default: return v >= utf8d_pkg::MinFour && v < utf8d_pkg::MaxPlusOne;
      endcase
    endfunction

    function void decode_byte(logic [7:0] b, logic str_end);
      logic [1:0]                n;
      logic [utf8d_pkg::CpW-1:0] lead_bits;
      logic [utf8d_pkg::CpW-1:0] v;
      if (conts_due == 2'd0) begin
        if (!b[7]) begin
          push_char({14'd0, b[6:0]}, 1'b0, str_end);
          return;
        end
        if (b[7:5] == 3'b110) begin
          n = 2'd1;
          lead_bits = {16'd0, b[4:0]};
        end else if (b[7:4] == 4'b1110) begin
          n = 2'd2;
          lead_bits = {17'd0, b[3:0]};
        end else if (b[7:3] == 5'b11110) begin
          n = 2'd3;
          lead_bits = {18'd0, b[2:0]};
        end else begin
          push_char(utf8d_pkg::ReplChar, 1'b1, str_end);
          return;
        end
        if (str_end) begin
          go_idle();
          push_char(utf8d_pkg::ReplChar, 1'b1, 1'b1);
        end else begin
          conts_due   = n;
          conts_total = n;
          payload     = lead_bits;
        end
        return;
      end
      if (b[7:6] != 2'b10) begin
        go_idle();
        push_char(utf8d_pkg::ReplChar, 1'b1, str_end);
        return;
      end
      payload   = {payload[utf8d_pkg::CpW-7:0], b[5:0]};
      conts_due = conts_due - 2'd1;
      if (conts_due == 2'd0) begin
        v = payload;
        n = conts_total;
        go_idle();
        if (scalar_ok(n, v)) begin
          push_char(v, 1'b0, str_end);
        end else begin
          push_char(utf8d_pkg::ReplChar, 1'b1, str_end);
        end
      end else if (str_end) begin
        go_idle();
        push_char(utf8d_pkg::ReplChar, 1'b1, 1'b1);
      end
    endfunction

    function void check_char(logic [utf8d_pkg::CpW-1:0] cp, logic bad, logic last);
      utf8d_pkg::result_t want;
      if (expected_chars.size() == 0) begin
        errors++;
        if (errors <= MaxReported) begin
          $display("%0t: unexpected result cp=%h replaced=%b last=%b",
                   $realtime, cp, bad, last);
        end
        return;
      end
      want = expected_chars.pop_front();
      if (cp !== want.code_point || bad !== want.replaced || last !== want.last) begin
        errors++;
        if (errors <= MaxReported) begin
          $display("%0t: mismatch cp=%h/%h replaced=%b/%b last=%b/%b (got/exp)",
                   $realtime, cp, want.code_point, bad, want.replaced,
                   last, want.last);
        end
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  byte_in_i;
  logic        string_end_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [20:0] code_point_o;
  logic        replaced_o;
  logic        last_of_string_o;

  decode_scoreboard sb = new();
  int  beats_sent;
  int  chars_seen;
  bit  tx_burst;
  bit  rx_burst;

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  utf8_stream_decoder u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .byte_in_i        (byte_in_i),
    .string_end_i     (string_end_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .code_point_o     (code_point_o),
    .replaced_o       (replaced_o),
    .last_of_string_o (last_of_string_o)
  );

  task automatic send_byte(input logic [7:0] b, input logic str_end);
    int gap;
    if ($urandom_range(0, 47) == 0) begin
      tx_burst = ~tx_burst;
    end
    gap = tx_burst ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    byte_in_i    <= b;
    string_end_i <= str_end;
    do @(posedge clk_i); while (!in_ready_o);
    sb.decode_byte(b, str_end);
    beats_sent++;
  endtask

  task automatic send_seq(input logic [7:0] seq_bytes [4], input int len,
                          input logic str_end);
    for (int i = 0; i < len; i++) begin
      if (i == len - 1) begin
        send_byte(seq_bytes[i], str_end);
      end else begin
        send_byte(seq_bytes[i], $urandom_range(0, 47) == 0);
      end
    end
  endtask

  initial begin
    rst_ni       <= 1'b0;
    in_valid_i   <= 1'b0;
    byte_in_i    <= 8'h00;
    string_end_i <= 1'b0;
    out_ready_i  <= 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin
    int stall;
    @(posedge clk_i iff rst_ni);
    forever begin
      if ($urandom_range(0, 39) == 0) begin
        rx_burst = ~rx_burst;
      end
      stall = rx_burst ? 0 : $urandom_range(0, 6);
      if (chars_seen == 150 || chars_seen == 900) begin
        stall = LongHoldOff;
      end
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      sb.check_char(code_point_o, replaced_o, last_of_string_o);
      chars_seen++;
    end
  end

  initial begin
    #1ms;
    $display("utf8_stream_decoder_tb: done, errors");
    $finish;
  end

  initial begin
    logic [7:0]  seq_bytes [4];
    logic [20:0] cp;
    logic [7:0]  bad_byte;
    int          kind;
    int          len;
    int          guard;
    @(posedge clk_i iff rst_ni);

    send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b1);
    send_byte(8'hC2, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hC0, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hE0, 1'b0);
    send_byte(8'h9F, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hED, 1'b0);
    send_byte(8'hA0, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hF0, 1'b0);
    send_byte(8'h9F, 1'b0);
    send_byte(8'h98, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hF4, 1'b0);
    send_byte(8'h90, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hE2, 1'b0);
    send_byte(8'h41, 1'b0);
    send_byte(8'hF7, 1'b1);
    send_byte(8'hE2, 1'b0);
    send_byte(8'h82, 1'b1);

    while (beats_sent < RandomBeats) begin
      kind = $urandom_range(0, 9);
      len  = $urandom_range(1, 4);
      for (int i = 1; i < 4; i++) begin
        seq_bytes[i] = {2'b10, 6'($urandom)};
      end
      case (len)
        1: seq_bytes[0] = {1'b0, 7'($urandom)};
        2: seq_bytes[0] = {3'b110, 5'($urandom)};
        3: seq_bytes[0] = {4'b1110, 4'($urandom)};
        default: seq_bytes[0] = {5'b11110, 3'($urandom)};
      endcase
      if (kind == 6) begin
        case (len)
          1: begin
            cp = 21'($urandom_range(0, 'h7F));
            seq_bytes[0] = {1'b0, cp[6:0]};
          end
          2: begin
            cp = 21'($urandom_range('h80, 'h7FF));
            seq_bytes[0] = {3'b110, cp[10:6]};
            seq_bytes[1] = {2'b10, cp[5:0]};
          end
          3: begin
            cp = 21'($urandom_range('h800, 'hFFFF));
            seq_bytes[0] = {4'b1110, cp[15:12]};
            seq_bytes[1] = {2'b10, cp[11:6]};
            seq_bytes[2] = {2'b10, cp[5:0]};
          end
          default: begin
            cp = 21'($urandom_range('h10000, 'h10FFFF));
            seq_bytes[0] = {5'b11110, cp[20:18]};
            seq_bytes[1] = {2'b10, cp[17:12]};
            seq_bytes[2] = {2'b10, cp[11:6]};
            seq_bytes[3] = {2'b10, cp[5:0]};
          end
        endcase
      end else if (kind == 7) begin
        len = 1;
        seq_bytes[0] = 8'($urandom);
      end else if (kind == 8 && len > 1) begin
        len = $urandom_range(1, len - 1);
      end else if (kind == 9 && len > 1) begin
        bad_byte = 8'($urandom);
        if (bad_byte[7:6] == 2'b10) begin
          bad_byte[6] = 1'b1;
        end
        seq_bytes[$urandom_range(1, len - 1)] = bad_byte;
      end
      send_seq(seq_bytes, len, $urandom_range(0, 7) == 0);
    end
    in_valid_i <= 1'b0;

    guard = 0;
    while (sb.expected_chars.size() != 0 && guard < DrainLimit) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.errors == 0 && sb.expected_chars.size() == 0) begin
      $display("utf8_stream_decoder_tb: done, clean");
    end else begin
      $display("utf8_stream_decoder_tb: done, errors");
    end
    $finish;
  end

endmodule
